@@ rtl/rcpwm_pkg.sv @@
package rcpwm_pkg;

   // default channel count
   localparam int RCPWM_CHANNELS = 4;

   // register reset values
   localparam logic [7:0]  MIN_PULSES_RST = 8'd10;
   localparam logic [15:0] MIN_WIDTH_RST  = 16'd1000;
   localparam logic [15:0] MAX_WIDTH_RST  = 16'd2000;
   localparam logic [7:0]  US_PER_TICK_RST = 8'd4;

   localparam logic [7:0]  COUNT_MAX = 8'd255;

   // word widths on the streams
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 16;

   // number of channels that show up in good_mask
   localparam int MASK_W = 4;

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_MIN_PULSES  = 2'd0,
      CSR_MIN_WIDTH   = 2'd1,
      CSR_MAX_WIDTH   = 2'd2,
      CSR_US_PER_TICK = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  min_pulses;
      logic [15:0] min_width_us;
      logic [15:0] max_width_us;
      logic [7:0]  us_per_tick;
   } cfg_type;

   typedef struct packed {
      logic [15:0] width_us;
      logic        in_range;
   } meas_type;

endpackage

@@ rtl/rcpwm_width.sv @@
module rcpwm_width
   import rcpwm_pkg::*;
(
   input  cfg_type     cfg,
   input  logic [15:0] start_time,
   input  logic [15:0] timer_value,
   output meas_type    meas
);

   logic [15:0] ticks;
   logic [23:0] product;

   always_comb begin
      ticks          = timer_value - start_time;       // wraps mod 2^16
      product        = ticks * {8'd0, cfg.us_per_tick};
      meas.width_us  = product[15:0];
      // inverted bounds accept nothing
      meas.in_range  = (product[15:0] >= cfg.min_width_us) &&
                       (product[15:0] <= cfg.max_width_us);
   end

endmodule

@@ rtl/rc_pwm_pulse_capture.sv @@
// RC servo PWM pulse width capture, per-channel failsafe good flags.
// Path: a req word goes into the input reg, then into the result reg, which drives rsp.
// Throughput: 1 word per cycle while rsp is not stalled; per-channel state is updated
// as the result reg loads, so the next word in the input reg already sees it.
// Reset (sync, active high): all channels wait for rising edge, counts/widths zero,
// not good; registers return to 10 / 1000 / 2000 / 4.
module rc_pwm_pulse_capture
   import rcpwm_pkg::*;
#(
   parameter int CHANNELS = RCPWM_CHANNELS
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] channel, [2] rising, [18:3] timer_value, [23:19] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic                  req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] report_channel, [17:2] width_us, [18] width_updated,
   // [22:19] good_mask, [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int MASK_N = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

   // ---------------- configuration registers ----------------
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulses   <= MIN_PULSES_RST;
         cfg_ff.min_width_us <= MIN_WIDTH_RST;
         cfg_ff.max_width_us <= MAX_WIDTH_RST;
         cfg_ff.us_per_tick  <= US_PER_TICK_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_PULSES:  cfg_ff.min_pulses   <= csr_data[7:0];
            CSR_MIN_WIDTH:   cfg_ff.min_width_us <= csr_data;
            CSR_MAX_WIDTH:   cfg_ff.max_width_us <= csr_data;
            CSR_US_PER_TICK: cfg_ff.us_per_tick  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic        s1_valid_ff;
   logic        s1_cmd_ff;
   logic [1:0]  s1_ch_ff;
   logic        s1_rising_ff;
   logic [15:0] s1_time_ff;
   logic        advance;   // result reg free to load
   logic        fire;      // word in input reg is processed this cycle

   assign advance    = !rsp_tvalid || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_cmd_ff    <= req_tuser;
         s1_ch_ff     <= req_tdata[1:0];
         s1_rising_ff <= req_tdata[2];
         s1_time_ff   <= req_tdata[18:3];
      end
   end

   // ---------------- per-channel state ----------------
   logic        expect_falling_ff [CHANNELS];
   logic [15:0] start_time_ff     [CHANNELS];
   logic [15:0] last_width_ff     [CHANNELS];
   logic [7:0]  pulse_count_ff    [CHANNELS];
   logic        good_ff           [CHANNELS];

   logic        expect_falling_in [CHANNELS];
   logic [15:0] start_time_in     [CHANNELS];
   logic [15:0] last_width_in     [CHANNELS];
   logic [7:0]  pulse_count_in    [CHANNELS];
   logic        good_in           [CHANNELS];

   // addressed channel, selected by one-hot compare
   logic        ch_hit;
   logic        sel_expect;
   logic [15:0] sel_start;
   logic [15:0] sel_last;
   meas_type    meas;
   logic        edge_update;

   always_comb begin
      ch_hit     = 1'b0;
      sel_expect = 1'b0;
      sel_start  = '0;
      sel_last   = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (int'(s1_ch_ff) == c) begin
            ch_hit     = 1'b1;
            sel_expect = expect_falling_ff[c];
            sel_start  = start_time_ff[c];
            sel_last   = last_width_ff[c];
         end
      end
   end

   rcpwm_width u_width (
      .cfg         (cfg_ff),
      .start_time  (sel_start),
      .timer_value (s1_time_ff),
      .meas        (meas)
   );

   // falling edge on an armed channel with an in-bounds width
   assign edge_update = (s1_cmd_ff == CMD_EDGE) && ch_hit && sel_expect &&
                        !s1_rising_ff && meas.in_range;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         expect_falling_in[c] = expect_falling_ff[c];
         start_time_in[c]     = start_time_ff[c];
         last_width_in[c]     = last_width_ff[c];
         pulse_count_in[c]    = pulse_count_ff[c];
         good_in[c]           = good_ff[c];
         if (fire) begin
            if (s1_cmd_ff == CMD_TICK) begin
               // period end: judge each channel, short ones re-arm
               if (pulse_count_ff[c] < cfg_ff.min_pulses) begin
                  expect_falling_in[c] = 1'b0;
                  good_in[c]           = 1'b0;
               end else begin
                  good_in[c] = 1'b1;
               end
               pulse_count_in[c] = '0;
            end else if (int'(s1_ch_ff) == c) begin
               if (!expect_falling_ff[c]) begin
                  if (s1_rising_ff) begin
                     start_time_in[c]     = s1_time_ff;
                     expect_falling_in[c] = 1'b1;
                  end
               end else if (!s1_rising_ff) begin
                  expect_falling_in[c] = 1'b0;
                  if (meas.in_range) begin
                     last_width_in[c] = meas.width_us;
                     if (pulse_count_ff[c] != COUNT_MAX) begin
                        pulse_count_in[c] = pulse_count_ff[c] + 8'd1;
                     end
                  end
               end
               // wrong polarity: nothing changes
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            expect_falling_ff[c] <= 1'b0;
            start_time_ff[c]     <= '0;
            last_width_ff[c]     <= '0;
            pulse_count_ff[c]    <= '0;
            good_ff[c]           <= 1'b0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            expect_falling_ff[c] <= expect_falling_in[c];
            start_time_ff[c]     <= start_time_in[c];
            last_width_ff[c]     <= last_width_in[c];
            pulse_count_ff[c]    <= pulse_count_in[c];
            good_ff[c]           <= good_in[c];
         end
      end
   end

   // ---------------- result register ----------------
   logic [MASK_W-1:0]     good_mask;
   logic [1:0]            rep_ch;
   logic [15:0]           rep_width;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   always_comb begin
      good_mask = '0;
      for (int c = 0; c < MASK_N; c++) begin
         good_mask[c] = good_in[c];   // flags after this word's update
      end
      if (s1_cmd_ff == CMD_TICK) begin
         rep_ch    = '0;
         rep_width = '0;
      end else begin
         rep_ch    = s1_ch_ff;
         // absent channel reports zero width
         rep_width = !ch_hit ? 16'd0 : (edge_update ? meas.width_us : sel_last);
      end
      rsp_data_in = {1'b0, good_mask, edge_update, rep_width, rep_ch};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   logic counts_clear;

   always_comb begin
      counts_clear = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         if (pulse_count_ff[c] != '0) begin
            counts_clear = 1'b0;
         end
      end
   end

   // a tick leaves every count at zero
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (s1_cmd_ff == CMD_TICK) |=> counts_clear)
      else $error("pulse counts not cleared by tick");

   // a tick result carries no channel, width or update flag
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      fire && (s1_cmd_ff == CMD_TICK) |=>
         rsp_tvalid && (rsp_tdata[18:0] == '0))
      else $error("tick result not zero");

   // a word held in the input reg is not dropped while the output stalls
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_time_ff) &&
         $stable(s1_ch_ff))
      else $error("input word lost under stall");

   // an update flag only comes from an edge word
   a_update_edge: assert property (@(posedge clock) disable iff (reset)
      fire && (s1_cmd_ff == CMD_TICK) |-> !edge_update)
      else $error("update flagged on tick");

endmodule

@@ tb/tb_rc_pwm_pulse_capture.sv @@
module tb_rc_pwm_pulse_capture;
   import rcpwm_pkg::*;

   // report word layout, MSB first so it lines up with rsp_tdata[22:0]
   typedef struct packed {
      logic [MASK_W-1:0] good_mask;
      logic              width_updated;
      logic [15:0]       width_us;
      logic [1:0]        report_channel;
   } report_type;

   // ------------------------------------------------------------------
   // Tracker: shadow copy of control regs and per-channel capture state.
   // note_event() runs at request accept, check_report() at report accept.
   // ------------------------------------------------------------------
   class capture_tracker;
      logic [7:0]  min_pulses;
      logic [15:0] min_width;
      logic [15:0] max_width;
      logic [7:0]  us_per_tick;

      bit          waiting_fall [RCPWM_CHANNELS];
      logic [15:0] t_start      [RCPWM_CHANNELS];
      logic [15:0] width_held   [RCPWM_CHANNELS];
      logic [7:0]  pulses       [RCPWM_CHANNELS];
      bit          good         [RCPWM_CHANNELS];

      report_type  pending_reports [$];
      int          errors;

      function new();
         min_pulses  = MIN_PULSES_RST;
         min_width   = MIN_WIDTH_RST;
         max_width   = MAX_WIDTH_RST;
         us_per_tick = US_PER_TICK_RST;
         for (int c = 0; c < RCPWM_CHANNELS; c++) begin
            waiting_fall[c] = 0;
            t_start[c]      = '0;
            width_held[c]   = '0;
            pulses[c]       = '0;
            good[c]         = 0;
         end
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] val);
         case (idx)
            CSR_MIN_PULSES:  min_pulses  = val[7:0];
            CSR_MIN_WIDTH:   min_width   = val;
            CSR_MAX_WIDTH:   max_width   = val;
            CSR_US_PER_TICK: us_per_tick = val[7:0];
            default: ;
         endcase
      endfunction

      function void note_event(cmd_type cmd, logic [1:0] ch, logic rising,
                               logic [15:0] t);
         report_type  r;
         logic [15:0] ticks;
         logic [31:0] prod;
         logic [15:0] w;
         r = '0;
         if (cmd == CMD_TICK) begin
            // period end: starved channels drop to not good and re-arm
            for (int c = 0; c < RCPWM_CHANNELS; c++) begin
               if (pulses[c] < min_pulses) begin
                  waiting_fall[c] = 0;
                  good[c]         = 0;
               end else begin
                  good[c] = 1;
               end
               pulses[c] = '0;
            end
         end else begin
            r.report_channel = ch;
            if (!waiting_fall[ch]) begin
               if (rising) begin
                  t_start[ch]      = t;
                  waiting_fall[ch] = 1;
               end
            end else if (!rising) begin
               waiting_fall[ch] = 0;
               ticks = t - t_start[ch];              // wraps at 16 bits
               prod  = 32'(ticks) * 32'(us_per_tick);
               w     = prod[15:0];                   // product wraps too
               if (w >= min_width && w <= max_width) begin
                  width_held[ch] = w;
                  if (pulses[ch] != COUNT_MAX)
                     pulses[ch] = pulses[ch] + 8'd1;
                  r.width_updated = 1'b1;
               end
            end
            r.width_us = width_held[ch];
         end
         for (int c = 0; c < RCPWM_CHANNELS && c < MASK_W; c++)
            r.good_mask[c] = good[c];
         pending_reports.push_back(r);
      endfunction

      function void check_report(logic [RSP_DATA_W-1:0] word);
         report_type got;
         report_type want;
         got = word[22:0];
         if (pending_reports.size() == 0) begin
            $error("report word %h with nothing pending", word);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.report_channel !== want.report_channel) begin
            $error("report_channel: expected %0d, got %0d",
                   want.report_channel, got.report_channel);
            errors++;
         end
         if (got.width_us !== want.width_us) begin
            $error("width_us: expected %0d, got %0d", want.width_us, got.width_us);
            errors++;
         end
         if (got.width_updated !== want.width_updated) begin
            $error("width_updated: expected %0d, got %0d",
                   want.width_updated, got.width_updated);
            errors++;
         end
         if (got.good_mask !== want.good_mask) begin
            $error("good_mask: expected %b, got %b", want.good_mask, got.good_mask);
            errors++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [1:0] channel, [2] rising, [18:3] timer_value
   logic                  req_tuser = 1'b0; // [0] cmd

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [1:0] report_channel, [17:2] width_us, [18] width_updated, [22:19] good_mask
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   capture_tracker tracker = new();

   // when set, neither side idles (burst stretches)
   bit no_idle = 0;
   int stall_left = 0;

   rc_pwm_pulse_capture uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 12 unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // ------------------------------------------------------------------
   // Report side: check every accepted word, then pick next ready.
   // Values sampled here are the ones from before the edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_report(rsp_tdata);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 20)
            stall_left = gap_len();
      end
   end

   // ------------------------------------------------------------------
   // Request driver: hold the word until accepted, note it, then maybe idle.
   // Valid stays high into the next word when no gap follows.
   // ------------------------------------------------------------------
   task automatic send_word(cmd_type cmd, logic [1:0] ch, logic rising,
                            logic [15:0] t);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, t, rising, ch};
      do @(posedge clock); while (!req_tready);
      tracker.note_event(cmd, ch, rising, t);
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every report is in; at least one edge passes
   // so valid is never dropped and raised in the same step
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_reports.size() != 0);
   endtask

   // write all four control regs, block idle
   task automatic program_regs(logic [7:0] pulses, logic [15:0] lo_us,
                               logic [15:0] hi_us, logic [7:0] scale);
      logic [15:0]   vals [4];
      csr_index_type idx;
      vals[CSR_MIN_PULSES]  = {8'h00, pulses};
      vals[CSR_MIN_WIDTH]   = lo_us;
      vals[CSR_MAX_WIDTH]   = hi_us;
      vals[CSR_US_PER_TICK] = {8'h00, scale};
      idx = CSR_MIN_PULSES;
      repeat (4) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[idx];
         do @(posedge clock); while (!csr_ready);
         tracker.set_reg(idx, vals[idx]);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
   endtask

   // one random word: mostly well-formed rising/falling pairs, plus ticks,
   // wrong-polarity edges and plain noise
   task automatic random_item();
      int          r;
      int          lo;
      int          hi;
      logic [1:0]  ch;
      logic [15:0] ticks;
      r  = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 3));
      if (r < 6) begin
         send_word(CMD_TICK, 2'($urandom), 1'($urandom), 16'($urandom));
      end else if (r < 14) begin
         send_word(cmd_type'(1'($urandom)), 2'($urandom), 1'($urandom),
                   16'($urandom));
      end else if (r < 22) begin
         // polarity opposite to the awaited one
         send_word(CMD_EDGE, ch, tracker.waiting_fall[ch], 16'($urandom));
      end else if (!tracker.waiting_fall[ch]) begin
         send_word(CMD_EDGE, ch, 1'b1, 16'($urandom));
      end else begin
         // closing edge: aim at the accept window, hit its edges often
         ticks = 16'($urandom);
         if (tracker.us_per_tick != 0 && $urandom_range(0, 9) < 8) begin
            lo = (int'(tracker.min_width) + int'(tracker.us_per_tick) - 1)
                 / int'(tracker.us_per_tick);
            hi = int'(tracker.max_width) / int'(tracker.us_per_tick);
            if (lo <= hi) begin
               case ($urandom_range(0, 5))
                  0:       ticks = 16'(lo);
                  1:       ticks = 16'(hi);
                  2:       ticks = 16'(lo - 1);
                  3:       ticks = 16'(hi + 1);
                  default: ticks = 16'($urandom_range(lo, hi));
               endcase
            end
         end
         send_word(CMD_EDGE, ch, 1'b0, tracker.t_start[ch] + ticks);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int p_pulses;
      int p_lo;
      int p_hi;
      int p_scale;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset values: 10 pulses, 1000..2000 us, 4 us/tick
      send_word(CMD_TICK, 2'd3, 1'b1, 16'hFFFF);   // tick, junk in other fields
      send_word(CMD_EDGE, 2'd0, 1'b0, 16'h0000);   // falling while armed for rising
      send_word(CMD_EDGE, 2'd0, 1'b1, 16'hFFF0);
      send_word(CMD_EDGE, 2'd0, 1'b1, 16'h1111);   // second rising ignored
      send_word(CMD_EDGE, 2'd0, 1'b0, 16'h0167);   // 375 ticks over timer wrap
      send_word(CMD_EDGE, 2'd1, 1'b1, 16'h0000);
      send_word(CMD_EDGE, 2'd1, 1'b0, 16'd250);    // exactly the low bound
      send_word(CMD_EDGE, 2'd2, 1'b1, 16'hFFFF);
      send_word(CMD_EDGE, 2'd2, 1'b0, 16'h01F3);   // exactly the high bound
      send_word(CMD_EDGE, 2'd3, 1'b1, 16'h0064);
      send_word(CMD_EDGE, 2'd3, 1'b0, 16'h015D);   // just below the window
      send_word(CMD_EDGE, 2'd3, 1'b1, 16'h8000);
      send_word(CMD_EDGE, 2'd3, 1'b0, 16'h81F5);   // just above the window
      send_word(CMD_EDGE, 2'd1, 1'b1, 16'h0000);
      send_word(CMD_EDGE, 2'd1, 1'b0, 16'h412C);   // product wraps into window
      send_word(CMD_TICK, 2'd0, 1'b0, 16'h0000);   // all starved, re-arm
      wait_drained();

      // --- zero scale, zero bounds, zero pulse requirement
      program_regs(8'd0, 16'd0, 16'd0, 8'd0);
      send_word(CMD_EDGE, 2'd0, 1'b1, 16'h1234);
      send_word(CMD_EDGE, 2'd0, 1'b0, 16'hABCD);   // width 0 accepted
      send_word(CMD_EDGE, 2'd2, 1'b1, 16'h5555);
      send_word(CMD_TICK, 2'd1, 1'b1, 16'h7777);   // all good, ch2 stays armed
      send_word(CMD_EDGE, 2'd2, 1'b0, 16'hAAAA);
      wait_drained();

      // --- inverted bounds, largest scale, largest pulse requirement
      program_regs(8'd255, 16'hFFFF, 16'h0000, 8'd255);
      send_word(CMD_EDGE, 2'd3, 1'b1, 16'h0000);
      send_word(CMD_EDGE, 2'd3, 1'b0, 16'd10);
      send_word(CMD_EDGE, 2'd1, 1'b1, 16'hFFFF);
      send_word(CMD_EDGE, 2'd1, 1'b0, 16'hFFFE);
      send_word(CMD_TICK, 2'd2, 1'b0, 16'h0F0F);   // good drops to none
      wait_drained();

      // --- pulse threshold: accept everything, ch0 gets exactly enough
      // pulses to turn good, ch1 one short
      program_regs(8'd3, 16'h0000, 16'hFFFF, 8'd1);
      send_word(CMD_TICK, 2'd0, 1'b0, 16'h0000);
      for (int i = 0; i < 3; i++) begin
         send_word(CMD_EDGE, 2'd0, 1'b1, 16'($urandom));
         send_word(CMD_EDGE, 2'd0, 1'b0, 16'($urandom));
         if (i < 2) begin
            send_word(CMD_EDGE, 2'd1, 1'b1, 16'($urandom));
            send_word(CMD_EDGE, 2'd1, 1'b0, 16'($urandom));
         end
      end
      send_word(CMD_TICK, 2'd3, 1'b1, 16'hFFFF);
      wait_drained();

      // --- random phases, a fresh reg setting each
      for (int p = 0; p < 5; p++) begin
         p_pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 3);
         p_lo     = $urandom_range(0, 3000);
         p_hi     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, p_lo)
                                                : p_lo + $urandom_range(0, 4000);
         p_scale  = $urandom_range(0, 1) ? $urandom_range(1, 16)
                                         : $urandom_range(1, 255);
         if (p == 0) begin
            p_lo = 1000; p_hi = 2000; p_scale = 4; p_pulses = 2;
         end
         no_idle = (p == 2);
         program_regs(8'(p_pulses), 16'(p_lo), 16'(p_hi), 8'(p_scale));
         for (int i = 0; i < 72; i++) begin
            if (p == 1 && i == 40)
               wait_drained();   // sender holds until the pipe is empty
            random_item();
         end
         wait_drained();
      end

      // drained; let the clock run on so anything stray still shows up
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
         $display("tb_rc_pwm_pulse_capture: done, clean");
      end else begin
         $display("tb_rc_pwm_pulse_capture: done, errors");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #(12 * 1000000);
      $display("tb_rc_pwm_pulse_capture: done, errors");
      $finish;
   end

endmodule
